### hdl/first_fit_buffer_recycle_pool_defines.svh
// assertion macros for the recycle pool
`ifndef FIRST_FIT_BUFFER_RECYCLE_POOL_DEFINES_SVH
`define FIRST_FIT_BUFFER_RECYCLE_POOL_DEFINES_SVH
`ifndef SYNTH
// checked outside reset
`define FFBRP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("recycle pool check failed");
// checked on every edge, reset included
`define FFBRP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("recycle pool check failed");
`else
`define FFBRP_ASSERT(label, clk, rst_n, prop)
`define FFBRP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### hdl/ffbrp_pkg.sv
`timescale 1ns / 1ps

package ffbrp_pkg;

    // outcome codes of a result beat
    localparam int OUTCOME_W = 2;
    localparam logic [OUTCOME_W-1:0] OC_REQ_HIT  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OC_REQ_BACK = 2'd1;
    localparam logic [OUTCOME_W-1:0] OC_REL_KEPT = 2'd2;
    localparam logic [OUTCOME_W-1:0] OC_REL_BACK = 2'd3;

    // function codes of an input beat
    localparam logic FUNC_RELEASE = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef logic [OUTCOME_W-1:0] outcome_t;

endpackage

### hdl/ffbrp_in_if.sv
`timescale 1ns / 1ps

interface ffbrp_in_if #(
    parameter int ID_BITS   = 16,
    parameter int SIZE_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic                 cacheable;
    logic [SIZE_BITS-1:0] byte_size;
    logic [ID_BITS-1:0]   buffer_id;

    modport source (
        output valid, func, cacheable, byte_size, buffer_id,
        input  ready
    );

    modport sink (
        input  valid, func, cacheable, byte_size, buffer_id,
        output ready
    );
endinterface

### hdl/ffbrp_out_if.sv
`timescale 1ns / 1ps

interface ffbrp_out_if #(
    parameter int ID_BITS    = 16,
    parameter int SIZE_BITS  = 32,
    parameter int POOL_DEPTH = 16
);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    logic                 valid;
    logic                 ready;
    ffbrp_pkg::outcome_t  outcome;
    logic [ID_BITS-1:0]   hit_id;
    logic [SIZE_BITS-1:0] hit_size;
    logic [CNT_W-1:0]     pool_count;

    modport source (
        output valid, outcome, hit_id, hit_size, pool_count,
        input  ready
    );

    modport sink (
        input  valid, outcome, hit_id, hit_size, pool_count,
        output ready
    );
endinterface

### hdl/ffbrp_ram.sv
`timescale 1ns / 1ps

module ffbrp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hdl/ffbrp_ctrl.sv
`timescale 1ns / 1ps
`include "first_fit_buffer_recycle_pool_defines.svh"

module ffbrp_ctrl #(
    parameter int POOL_DEPTH = 16,
    parameter int ID_BITS    = 16,
    parameter int SIZE_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ffbrp_in_if.sink                        in_ch,
    ffbrp_out_if.source                     out_ch,
    output logic                            mem_we,
    output logic [$clog2(POOL_DEPTH)-1:0]   mem_waddr,
    output logic [ID_BITS+SIZE_BITS-1:0]    mem_wdata,
    output logic [$clog2(POOL_DEPTH)-1:0]   mem_raddr,
    input  logic [ID_BITS+SIZE_BITS-1:0]    mem_rdata
);
    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [SIZE_BITS-1:0] req_size_reg, req_size_next;
    ffbrp_pkg::outcome_t  res_outcome_reg, res_outcome_next;
    logic [ID_BITS-1:0]   res_id_reg, res_id_next;
    logic [SIZE_BITS-1:0] res_size_reg, res_size_next;

    logic                 out_valid_reg, out_valid_next;
    ffbrp_pkg::outcome_t  out_outcome_reg, out_outcome_next;
    logic [ID_BITS-1:0]   out_id_reg, out_id_next;
    logic [SIZE_BITS-1:0] out_size_reg, out_size_next;
    logic [CNT_W-1:0]     out_count_reg, out_count_next;

    logic                 in_fire;
    logic                 out_free;
    logic [CNT_W-1:0]     idx_plus1;
    logic [CNT_W:0]       idx_plus2;
    logic [SIZE_BITS-1:0] rd_size;
    logic [ID_BITS-1:0]   rd_id;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign idx_plus1   = idx_reg + CNT_W'(1);
    assign idx_plus2   = {1'b0, idx_reg} + (CNT_W + 1)'(2);
    assign rd_size     = mem_rdata[SIZE_BITS-1:0];
    assign rd_id       = mem_rdata[ID_BITS+SIZE_BITS-1:SIZE_BITS];

    // sequencer: append on a cacheable release with room, first-fit scan on a cacheable request, compaction after a hit
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        req_size_next    = req_size_reg;
        res_outcome_next = res_outcome_reg;
        res_id_next      = res_id_reg;
        res_size_next    = res_size_reg;
        mem_we           = 1'b0;
        mem_waddr        = count_reg[IDX_W-1:0];
        mem_wdata        = {in_ch.buffer_id, in_ch.byte_size};
        mem_raddr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_id_next   = '0;
                    res_size_next = '0;
                    idx_next      = '0;
                    req_size_next = in_ch.byte_size;
                    if (in_ch.func == ffbrp_pkg::FUNC_REQUEST)
                    begin
                        if (in_ch.cacheable && (count_reg != '0))
                        begin
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            res_outcome_next = ffbrp_pkg::OC_REQ_BACK;
                            state_next       = ST_EMIT;
                        end
                    end
                    else
                    begin
                        if (in_ch.cacheable && (count_reg < DEPTH_CNT))
                        begin
                            mem_we           = 1'b1;
                            count_next       = count_reg + CNT_W'(1);
                            res_outcome_next = ffbrp_pkg::OC_REL_KEPT;
                        end
                        else
                        begin
                            res_outcome_next = ffbrp_pkg::OC_REL_BACK;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SCAN:
            begin
                // read data holds entry idx; fetch the next one alongside
                mem_raddr = idx_plus1[IDX_W-1:0];
                if (rd_size >= req_size_reg)
                begin
                    res_outcome_next = ffbrp_pkg::OC_REQ_HIT;
                    res_id_next      = rd_id;
                    res_size_next    = rd_size;
                    count_next       = count_reg - CNT_W'(1);
                    state_next       = (idx_plus1 < count_reg) ? ST_SHIFT : ST_EMIT;
                end
                else if (idx_plus1 < count_reg)
                begin
                    idx_next = idx_plus1;
                end
                else
                begin
                    res_outcome_next = ffbrp_pkg::OC_REQ_BACK;
                    state_next       = ST_EMIT;
                end
            end

            ST_SHIFT:
            begin
                // read data holds entry idx+1; move it down one place
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IDX_W-1:0];
                mem_wdata = mem_rdata;
                mem_raddr = idx_plus2[IDX_W-1:0];
                idx_next  = idx_plus1;
                if (idx_plus1 >= count_reg)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_outcome_next = out_outcome_reg;
        out_id_next      = out_id_reg;
        out_size_next    = out_size_reg;
        out_count_next   = out_count_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_valid_next   = 1'b1;
            out_outcome_next = res_outcome_reg;
            out_id_next      = res_id_reg;
            out_size_next    = res_size_reg;
            out_count_next   = count_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        req_size_reg    <= req_size_next;
        res_outcome_reg <= res_outcome_next;
        res_id_reg      <= res_id_next;
        res_size_reg    <= res_size_next;
        out_outcome_reg <= out_outcome_next;
        out_id_reg      <= out_id_next;
        out_size_reg    <= out_size_next;
        out_count_reg   <= out_count_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.outcome    = out_outcome_reg;
    assign out_ch.hit_id     = out_id_reg;
    assign out_ch.hit_size   = out_size_reg;
    assign out_ch.pool_count = out_count_reg;

    // checks
    `FFBRP_ASSERT(a_count_bound, clk, rst_n, count_reg <= DEPTH_CNT)
    `FFBRP_ASSERT(a_scan_in_range, clk, rst_n, (state_reg == ST_SCAN) |-> (idx_reg < count_reg))
    `FFBRP_ASSERT(a_shift_in_range, clk, rst_n, (state_reg == ST_SHIFT) |-> (idx_reg < count_reg))
    `FFBRP_ASSERT(a_count_step, clk, rst_n, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1)) || (count_reg + CNT_W'(1) == $past(count_reg)))
    `FFBRP_ASSERT(a_no_write_when_full, clk, rst_n, (mem_we && (state_reg == ST_IDLE)) |-> (count_reg < DEPTH_CNT))
endmodule

### hdl/first_fit_buffer_recycle_pool.sv
`timescale 1ns / 1ps

// First-fit buffer recycle pool. Handles and sizes of released cacheable
// buffers sit in one entry memory in release order, oldest at the bottom.
// A release beat is taken while idle and its result is loaded into the
// output register once that register is free. A cacheable request reads
// the memory one entry per cycle from the oldest until a size fits, then
// moves every later entry down by one place, again one entry per cycle;
// scan and compaction together cover the entries in the pool, one at a
// time through the single read port of the entry memory. A new beat is
// taken while an earlier result still waits in the output register; the
// pool has no clearing pass after reset.
module first_fit_buffer_recycle_pool #(
    parameter int POOL_DEPTH = 16,
    parameter int ID_BITS    = 16,
    parameter int SIZE_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ffbrp_in_if.sink    in_ch,
    ffbrp_out_if.source out_ch
);
    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam int ENT_W = ID_BITS + SIZE_BITS;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    // entry memory: handle above size
    ffbrp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (POOL_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer and output register
    ffbrp_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .ID_BITS    (ID_BITS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );
endmodule
